[hdl/ngga_pkg.sv]
// Shared constants and types for the GGA position capture block.
`timescale 1ns / 1ps

package ngga_pkg;

  // Largest number of characters kept per coordinate text (5..16).
  localparam int unsigned FieldChars = 13;

  localparam int unsigned StepW  = 6;
  localparam int unsigned IndexW = 4;
  localparam int unsigned CharW  = 8;

  localparam logic [CharW-1:0] ChG     = 8'h47;
  localparam logic [CharW-1:0] ChA     = 8'h41;
  localparam logic [CharW-1:0] ChComma = 8'h2c;
  localparam logic [CharW-1:0] ChS     = 8'h53;
  localparam logic [CharW-1:0] ChW     = 8'h57;

  // Parser positions.
  localparam logic [StepW-1:0] StReset    = StepW'(0);
  localparam logic [StepW-1:0] StSearch   = StepW'(1);
  localparam logic [StepW-1:0] StG2       = StepW'(2);
  localparam logic [StepW-1:0] StA        = StepW'(3);
  localparam logic [StepW-1:0] StComma1   = StepW'(4);
  localparam logic [StepW-1:0] StComma2   = StepW'(5);
  localparam logic [StepW-1:0] StLat0     = StepW'(6);
  localparam logic [StepW-1:0] StLatHemi  = StepW'(6 + FieldChars);
  localparam logic [StepW-1:0] StLonComma = StepW'(7 + FieldChars);
  localparam logic [StepW-1:0] StLon0     = StepW'(8 + FieldChars);
  localparam logic [StepW-1:0] StLonHemi  = StepW'(8 + 2 * FieldChars);
  localparam logic [StepW-1:0] StDone     = StepW'(9 + 2 * FieldChars);

  localparam logic FieldLat = 1'b0;
  localparam logic FieldLon = 1'b1;

  typedef struct packed {
    logic              capture_valid;
    logic              capture_field;
    logic [IndexW-1:0] capture_index;
    logic [CharW-1:0]  capture_char;
    logic              lat_south;
    logic              long_west;
    logic              fix_seen;
    logic [StepW-1:0]  parse_position;
  } result_t;

endpackage

[hdl/ngga_in_reg.sv]
// Input register: holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module ngga_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ngga_pkg::CharW-1:0] rx_byte_i,
  input  logic                       take_i,
  output logic                       byte_valid_o,
  output logic [ngga_pkg::CharW-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [ngga_pkg::CharW-1:0] byte_q;
  logic                       load;

  // Stall only while a held item cannot move on this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

[hdl/ngga_parser.sv]
// Parser state and the per-byte step that forms one result.
`timescale 1ns / 1ps

module ngga_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [ngga_pkg::CharW-1:0] byte_i,
  output ngga_pkg::result_t          result_o
);

  logic [ngga_pkg::StepW-1:0] step_q, step_d;
  logic                       south_q, south_d;
  logic                       west_q, west_d;
  logic                       fix_q, fix_d;
  logic                       cap_valid;
  logic                       cap_field;
  logic [ngga_pkg::StepW-1:0] cap_offset;
  logic                       is_comma;

  assign is_comma = (byte_i == ngga_pkg::ChComma);

  always_comb begin
    step_d     = step_q;
    south_d    = south_q;
    west_d     = west_q;
    fix_d      = fix_q;
    cap_valid  = 1'b0;
    cap_field  = ngga_pkg::FieldLat;
    cap_offset = '0;
    if (step_q == ngga_pkg::StSearch) begin
      if (byte_i == ngga_pkg::ChG) begin
        step_d = ngga_pkg::StG2;
      end
    end else if (step_q == ngga_pkg::StG2) begin
      step_d = (byte_i == ngga_pkg::ChG) ? ngga_pkg::StA : ngga_pkg::StSearch;
    end else if (step_q == ngga_pkg::StA) begin
      step_d = (byte_i == ngga_pkg::ChA) ? ngga_pkg::StComma1 : ngga_pkg::StSearch;
    end else if (step_q == ngga_pkg::StComma1 || step_q == ngga_pkg::StComma2) begin
      if (is_comma) begin
        step_d = step_q + 1'b1;
      end
    end else if (step_q == ngga_pkg::StLat0) begin
      // Empty latitude: restart the search.
      if (is_comma) begin
        step_d = ngga_pkg::StSearch;
      end else begin
        cap_valid = 1'b1;
        step_d    = step_q + 1'b1;
      end
    end else if (step_q > ngga_pkg::StLat0 && step_q < ngga_pkg::StLatHemi) begin
      if (is_comma) begin
        step_d = ngga_pkg::StLatHemi;
      end else begin
        cap_valid  = 1'b1;
        cap_offset = step_q - ngga_pkg::StLat0;
        step_d     = step_q + 1'b1;
      end
    end else if (step_q == ngga_pkg::StLatHemi) begin
      if (byte_i == ngga_pkg::ChS) begin
        south_d = 1'b1;
      end
      step_d = step_q + 1'b1;
    end else if (step_q == ngga_pkg::StLonComma) begin
      if (is_comma) begin
        step_d = step_q + 1'b1;
      end
    end else if (step_q == ngga_pkg::StLon0) begin
      // First longitude character is taken as is, comma or not.
      cap_valid = 1'b1;
      cap_field = ngga_pkg::FieldLon;
      step_d    = step_q + 1'b1;
    end else if (step_q > ngga_pkg::StLon0 && step_q < ngga_pkg::StLonHemi) begin
      if (is_comma) begin
        step_d = ngga_pkg::StLonHemi;
      end else begin
        cap_valid  = 1'b1;
        cap_field  = ngga_pkg::FieldLon;
        cap_offset = step_q - ngga_pkg::StLon0;
        step_d     = step_q + 1'b1;
      end
    end else if (step_q == ngga_pkg::StLonHemi) begin
      if (byte_i == ngga_pkg::ChW) begin
        west_d = 1'b1;
      end
      step_d = step_q + 1'b1;
    end else if (step_q == ngga_pkg::StDone) begin
      fix_d = 1'b1;
    end else begin
      // Reset position and unused codes go to the search.
      step_d = ngga_pkg::StSearch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ngga_pkg::StReset;
      south_q <= 1'b0;
      west_q  <= 1'b0;
      fix_q   <= 1'b0;
    end else if (step_i) begin
      step_q  <= step_d;
      south_q <= south_d;
      west_q  <= west_d;
      fix_q   <= fix_d;
    end
  end

  always_comb begin
    result_o.capture_valid  = cap_valid;
    result_o.capture_field  = cap_field;
    result_o.capture_index  = cap_offset[ngga_pkg::IndexW-1:0];
    result_o.capture_char   = cap_valid ? byte_i : '0;
    result_o.lat_south      = south_d;
    result_o.long_west      = west_d;
    result_o.fix_seen       = fix_d;
    result_o.parse_position = step_d;
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= ngga_pkg::StDone)
    else $error("parser position beyond done");

  a_fix_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fix_q |-> step_q == ngga_pkg::StDone)
    else $error("fix flag set outside done position");

  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (south_q || west_q || fix_q) |=>
      (south_q >= $past(south_q)) && (west_q >= $past(west_q)) && (fix_q >= $past(fix_q)))
    else $error("sticky flag cleared");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_valid |-> cap_offset < ngga_pkg::StepW'(ngga_pkg::FieldChars))
    else $error("capture index out of range");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(step_q))
    else $error("parser position moved without a byte");
`endif

endmodule

[hdl/ngga_out_reg.sv]
// Result register with valid and stall toward the consumer.
`timescale 1ns / 1ps

module ngga_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  ngga_pkg::result_t result_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ngga_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  ngga_pkg::result_t result_q;

  // Advance when empty or when the held item leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> valid_q && $stable(result_q))
    else $error("result changed while stalled");
`endif

endmodule

[hdl/nmea_gga_position_capture_unit.sv]
// Top level: GGA sentence position capture, one result per received byte.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i, in_stall_o | rx_byte_i
//   result  | out       | out_valid_o, out_stall_i | capture_*_o, flags, parse_position_o
//
// One byte per cycle unless out_stall_i holds; accepted bytes enter the input register.
// The parser step sits between the input register and the result register.
// Reset clears the parser to position 0 and all sticky flags; no clearing pass.
// A new byte is taken while a result waits, as long as the input register frees.
// A stalled result holds its value; the input stalls only when both registers are full.
`timescale 1ns / 1ps

module nmea_gga_position_capture_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ngga_pkg::CharW-1:0]  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        capture_valid_o,
  output logic                        capture_field_o,
  output logic [ngga_pkg::IndexW-1:0] capture_index_o,
  output logic [ngga_pkg::CharW-1:0]  capture_char_o,
  output logic                        lat_south_o,
  output logic                        long_west_o,
  output logic                        fix_seen_o,
  output logic [ngga_pkg::StepW-1:0]  parse_position_o
);

  logic                       byte_valid;
  logic [ngga_pkg::CharW-1:0] byte_q;
  logic                       out_ready;
  logic                       take;
  ngga_pkg::result_t          step_result;
  ngga_pkg::result_t          out_result;

  assign take = byte_valid && out_ready;

  ngga_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .take_i       (take),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q)
  );

  ngga_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .byte_i   (byte_q),
    .result_o (step_result)
  );

  ngga_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (byte_valid),
    .result_i     (step_result),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (out_result)
  );

  assign capture_valid_o  = out_result.capture_valid;
  assign capture_field_o  = out_result.capture_field;
  assign capture_index_o  = out_result.capture_index;
  assign capture_char_o   = out_result.capture_char;
  assign lat_south_o      = out_result.lat_south;
  assign long_west_o      = out_result.long_west;
  assign fix_seen_o       = out_result.fix_seen;
  assign parse_position_o = out_result.parse_position;

endmodule
